@@ rtl/core/ssv_pkg.sv @@
// Shared types, constants and helpers for the sensor sample validator.
`timescale 1ns / 1ps
`default_nettype none

package ssv_pkg;

    localparam int SAMPLE_W = 24;
    localparam int RUN_W    = 8;
    localparam int CFG_AW   = 3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_AW-1:0] {
        CFG_MIN_RAW         = 3'd0,
        CFG_MAX_RAW         = 3'd1,
        CFG_MAX_STEP        = 3'd2,
        CFG_MAX_INVALID_RUN = 3'd3,
        CFG_STEP_CHECK_EN   = 3'd4,
        CFG_BUS_ERROR_LIMIT = 3'd5
    } cfg_index_t;

    localparam logic [SAMPLE_W-1:0] MIN_RAW_RST   = '0;
    localparam logic [SAMPLE_W-1:0] MAX_RAW_RST   = '1;
    localparam logic [SAMPLE_W-1:0] MAX_STEP_RST  = 24'd65535;
    localparam logic [RUN_W-1:0]    RUN_LIMIT_RST = 8'd10;

    typedef struct packed {
        logic [SAMPLE_W-1:0] min_raw;
        logic [SAMPLE_W-1:0] max_raw;
        logic [SAMPLE_W-1:0] max_step;
        logic [RUN_W-1:0]    max_invalid_run;
        logic                step_check_enable;
        logic [RUN_W-1:0]    bus_error_limit;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic                sample_valid;
        logic                bus_reinit;
        logic                baseline_adopted;
    } result_t;

    // Run counters stick at all-ones
    function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
        sat_inc = (v == '1) ? v : v + RUN_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sensor_sample_validator_unit.sv @@
// Top level of the sensor sample validator: stream ports, stages and config.
`timescale 1ns / 1ps
`default_nettype none

// Sensor sample validator. Each input transfer carries one 24-bit raw reading
// and a read-ok flag; each produces exactly one output transfer with the
// sample passed on (0 for a failed read), an accept flag, a bus-reinit flag
// and a baseline-adopted flag. The block is two registered stages: an input
// register, then the range/step checks and run-counter update feeding an
// output register. It sustains one transfer per clock while m_tready stays
// high; an item passes the input register and then the output register
// before m_tvalid rises for it. The state (baseline, pending flag,
// invalid and bus-error runs) updates as an item leaves the input stage, so
// back-to-back items see each other's effects in order. Configuration
// registers are written through cfg_we/cfg_index/cfg_wdata and take effect on
// the next cycle; write them only while no transfer is in flight. Unmapped
// indexes are ignored. A run limit of 0 acts as 1.
module sensor_sample_validator_unit
    import ssv_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [23:0]         s_tdata,    // [23:0] raw_sample
    input  wire logic [0:0]          s_tuser,    // [0] read_ok

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [23:0]              m_tdata,    // [23:0] sample_value
    output logic [2:0]               m_tuser,    // [0] sample_valid, [1] bus_reinit,
                                                 // [2] baseline_adopted

    input  wire logic                cfg_we,
    input  wire logic [CFG_AW-1:0]   cfg_index,
    input  wire logic [SAMPLE_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    result_t res;

    logic                in_vld_reg,  in_vld_next;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                in_ok_reg;
    logic                out_vld_reg, out_vld_next;
    result_t             out_res_reg;
    logic                advance;

    // output stage can take a new result when empty or being drained
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;

    always_comb begin
        in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
        out_vld_next = advance ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_sample_reg <= s_tdata;
            in_ok_reg     <= s_tuser[0];
        end
        if (advance && in_vld_reg) begin
            out_res_reg <= res;
        end
    end

    ssv_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ssv_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .upd        (advance && in_vld_reg),
        .raw_sample (in_sample_reg),
        .read_ok    (in_ok_reg),
        .res        (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_res_reg.sample_value;
    assign m_tuser  = {out_res_reg.baseline_adopted, out_res_reg.bus_reinit,
                       out_res_reg.sample_valid};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output transfer changed while stalled");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !advance) |=> in_vld_reg)
        else $error("input stage item lost while stalled");

    a_move_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && advance) |=> out_vld_reg)
        else $error("item left input stage without reaching output");

endmodule

`default_nettype wire

@@ rtl/core/ssv_cfg_regs.sv @@
// Configuration register bank of the sensor sample validator.
`timescale 1ns / 1ps
`default_nettype none

module ssv_cfg_regs
    import ssv_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [CFG_AW-1:0]   cfg_index,
    input  wire logic [SAMPLE_W-1:0] cfg_wdata,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIN_RAW:         cfg_next.min_raw           = cfg_wdata;
                CFG_MAX_RAW:         cfg_next.max_raw           = cfg_wdata;
                CFG_MAX_STEP:        cfg_next.max_step          = cfg_wdata;
                CFG_MAX_INVALID_RUN: cfg_next.max_invalid_run   = cfg_wdata[RUN_W-1:0];
                CFG_STEP_CHECK_EN:   cfg_next.step_check_enable = cfg_wdata[0];
                CFG_BUS_ERROR_LIMIT: cfg_next.bus_error_limit   = cfg_wdata[RUN_W-1:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_raw           <= MIN_RAW_RST;
            cfg_reg.max_raw           <= MAX_RAW_RST;
            cfg_reg.max_step          <= MAX_STEP_RST;
            cfg_reg.max_invalid_run   <= RUN_LIMIT_RST;
            cfg_reg.step_check_enable <= 1'b1;
            cfg_reg.bus_error_limit   <= RUN_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/ssv_core.sv @@
// Validation logic and run/baseline state of the sensor sample validator.
`timescale 1ns / 1ps
`default_nettype none

module ssv_core
    import ssv_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cfg_t                cfg,
    input  wire logic                upd,        // item in the input stage moves on
    input  wire logic [SAMPLE_W-1:0] raw_sample,
    input  wire logic                read_ok,
    output result_t                  res
);

    logic [SAMPLE_W-1:0] baseline_reg,  baseline_next;
    logic                pending_reg,   pending_next;
    logic [RUN_W-1:0]    inv_run_reg,   inv_run_next;
    logic [RUN_W-1:0]    ber_run_reg,   ber_run_next;

    logic [SAMPLE_W-1:0] sample;
    logic [RUN_W-1:0]    ber_inc;
    logic [RUN_W-1:0]    inv_after_bus;
    logic [RUN_W-1:0]    inv_inc;
    logic                pend_after_bus;
    logic                reinit;
    logic                out_of_range;
    logic [SAMPLE_W-1:0] diff;
    logic                step_bad;
    logic                inv_limit;

    always_comb begin
        // bus error tracking first
        sample         = read_ok ? raw_sample : '0;
        ber_inc        = sat_inc(ber_run_reg);
        reinit         = !read_ok && (ber_inc >= cfg.bus_error_limit);
        ber_run_next   = (read_ok || reinit) ? '0 : ber_inc;
        pend_after_bus = pending_reg | reinit;
        inv_after_bus  = reinit ? '0 : inv_run_reg;

        out_of_range = (sample <= cfg.min_raw) || (sample >= cfg.max_raw);
        diff         = (sample > baseline_reg) ? sample - baseline_reg
                                               : baseline_reg - sample;
        step_bad     = cfg.step_check_enable && !pend_after_bus && (diff > cfg.max_step);
        inv_inc      = sat_inc(inv_after_bus);
        inv_limit    = inv_inc >= cfg.max_invalid_run;

        baseline_next        = baseline_reg;
        pending_next         = pend_after_bus;
        inv_run_next         = inv_after_bus;
        res.sample_value     = sample;
        res.sample_valid     = 1'b0;
        res.bus_reinit       = reinit;
        res.baseline_adopted = 1'b0;

        priority if (out_of_range) begin
            inv_run_next = inv_limit ? '0 : inv_inc;
            if (inv_limit) begin
                pending_next = 1'b1;
            end
        end else if (step_bad) begin
            inv_run_next = inv_limit ? '0 : inv_inc;
            if (inv_limit) begin
                // persistent step becomes the new baseline
                baseline_next        = sample;
                pending_next         = 1'b0;
                res.sample_valid     = 1'b1;
                res.baseline_adopted = 1'b1;
            end
        end else begin
            inv_run_next     = '0;
            baseline_next    = sample;
            pending_next     = 1'b0;
            res.sample_valid = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= '0;
            pending_reg  <= 1'b1;
            inv_run_reg  <= '0;
            ber_run_reg  <= '0;
        end else if (upd) begin
            baseline_reg <= baseline_next;
            pending_reg  <= pending_next;
            inv_run_reg  <= inv_run_next;
            ber_run_reg  <= ber_run_next;
        end
    end

    a_valid_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd && res.sample_valid) |=> !pending_reg)
        else $error("accepted sample left baseline pending");

    a_reinit_rejects: assert property (@(posedge aclk) disable iff (!aresetn)
        res.bus_reinit |-> (!res.sample_valid && res.sample_value == '0))
        else $error("bus reinit with accepted or nonzero sample");

    a_adopt_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        res.baseline_adopted |-> res.sample_valid)
        else $error("baseline adopted without accepting sample");

    a_good_read_clears_ber: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd && read_ok) |=> (ber_run_reg == '0))
        else $error("bus error run not cleared by good read");

endmodule

`default_nettype wire
